// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// ===== design/paca_pkg.sv =====
// Types and constants of the paged cache page allocator.
package paca_pkg;
   localparam int SP_COUNT_DEF    = 4;
   localparam int PAGE_TOKENS_DEF = 32;
   localparam int SLOTS_DEF       = 32;
   localparam int MAX_PAGES_DEF   = 64;
   localparam int FREE_DEPTH_DEF  = 256;

   localparam int OP_W     = 2;
   localparam int SLOT_W   = 5;
   localparam int END_W    = 16;
   localparam int SHARD_W  = 2;
   localparam int ENTRY_W  = 8;
   localparam int ID_W     = 16;
   localparam int FCOUNT_W = 9;
   localparam int PAGE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int PCOUNT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_REQUEST, OP_LOAD_ENTRY, OP_SET_COUNT, OP_READ_TABLE
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE, ST_UNCHANGED, ST_NO_IDS, ST_TOO_BIG
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_NEED, S_DECIDE, S_SCAN, S_CHECK, S_SH_START, S_PUSH_RD,
      S_PUSH_WR, S_POP_CHK, S_POP_WR, S_TRD, S_DONE
   } state_type;
endpackage

// ===== design/paca_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module paca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/paged_cache_page_allocator_core.sv =====
// Paged cache page allocator: page table and shard free-ID stacks in RAM.
// A request counts the pages it needs, scans the old and new pages per shard and checks the
// stacks, then per shard pushes the old IDs of a reset request and pops the new IDs.
// One item is in work at a time; a result waits in the output register.
// Synchronous reset clears counts and control; RAM contents are not cleared.
`include "assert_macros.svh"
module paged_cache_page_allocator_core
   import paca_pkg::*;
#(
   parameter int SP_COUNT    = SP_COUNT_DEF,
   parameter int PAGE_TOKENS = PAGE_TOKENS_DEF,
   parameter int SLOTS       = SLOTS_DEF,
   parameter int MAX_PAGES   = MAX_PAGES_DEF,
   parameter int FREE_DEPTH  = FREE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic                req_reset_request,
   input  logic [END_W-1:0]    req_end_position,
   input  logic [SHARD_W-1:0]  req_shard_index,
   input  logic [ENTRY_W-1:0]  req_entry_index,
   input  logic [ID_W-1:0]     req_entry_value,
   input  logic [FCOUNT_W-1:0] req_free_count,
   input  logic [PAGE_W-1:0]   req_page_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PCOUNT_W-1:0] rsp_page_count,
   output logic [ID_W-1:0]     rsp_read_value
);
   // Widths derived from the parameters.
   localparam int SH_W   = (SP_COUNT > 1) ? $clog2(SP_COUNT) : 1;
   localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLX_W  = (SL_W > SLOT_W) ? SL_W : SLOT_W;
   localparam int SHX_W  = (SH_W > SHARD_W) ? SH_W : SHARD_W;
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int PG_W   = $clog2(MAX_PAGES + SP_COUNT + 1);
   localparam int FC_W   = $clog2(FREE_DEPTH + 1);
   localparam int CW     = ((FC_W > CNT_W) ? FC_W : CNT_W) + 1;
   localparam int TA_W   = (SLOTS * MAX_PAGES > 1) ? $clog2(SLOTS * MAX_PAGES) : 1;
   localparam int FA_W   = (SP_COUNT * FREE_DEPTH > 1) ? $clog2(SP_COUNT * FREE_DEPTH) : 1;
   localparam int ACC_W  = $clog2((2 ** END_W) + PAGE_TOKENS + 1);
   localparam int LIMIT  = MAX_PAGES * PAGE_TOKENS;

   // Control state.
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] alloc_ff [SLOTS];
   logic [CNT_W-1:0] alloc_in [SLOTS];
   logic [FC_W-1:0]  fcnt_ff [SP_COUNT];
   logic [FC_W-1:0]  fcnt_in [SP_COUNT];

   // Working registers of the item in progress.
   logic [SL_W-1:0]  slot_ff, slot_in;
   logic             rst_ff, rst_in;
   logic [END_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0] old_ff, old_in;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0] next_ff, next_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [PG_W-1:0]  pg_ff, pg_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [CNT_W-1:0] oc_ff [SP_COUNT];
   logic [CNT_W-1:0] oc_in [SP_COUNT];
   logic [CNT_W-1:0] nc_ff [SP_COUNT];
   logic [CNT_W-1:0] nc_in [SP_COUNT];
   logic [FC_W-1:0]  c_ff, c_in;
   status_type       res_status_ff, res_status_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [ID_W-1:0]  res_val_ff, res_val_in;

   // Output register.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PCOUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [ID_W-1:0]     rsp_value_ff, rsp_value_in;

   // RAM ports.
   logic            t_we, f_we;
   logic [TA_W-1:0] t_waddr, t_raddr;
   logic [ID_W-1:0] t_wdata, t_rdata;
   logic [FA_W-1:0] f_waddr, f_raddr;
   logic [ID_W-1:0] f_wdata, f_rdata;

   // Decode of the incoming beat.
   logic [SLX_W-1:0] slot_x;
   logic [SL_W-1:0]  slot_idx;
   logic [SHX_W-1:0] shard_x;
   logic [SH_W-1:0]  shard_idx;
   logic             slot_ok, shard_ok, entry_ok, page_ok, too_big, page_live;
   logic [FA_W-1:0]  load_addr;
   logic [TA_W-1:0]  read_addr;

   // Request datapath.
   logic [CNT_W-1:0] next_w, limit_w;
   logic [TA_W-1:0]  t_addr_w;
   logic [FA_W-1:0]  push_addr, pop_addr;
   logic             pop_go, chk_err, last_shard;
   logic [SH_W-1:0]  sh_step;
   logic [CW-1:0]    sum_w [SP_COUNT];
   logic             fc_bound_ok, alloc_bound_ok;

   assign slot_x    = SLX_W'(req_slot);
   assign slot_idx  = slot_x[SL_W-1:0];
   assign shard_x   = SHX_W'(req_shard_index);
   assign shard_idx = shard_x[SH_W-1:0];
   assign slot_ok   = 32'(req_slot) < 32'(SLOTS);
   assign shard_ok  = 32'(req_shard_index) < 32'(SP_COUNT);
   assign entry_ok  = 32'(req_entry_index) < 32'(FREE_DEPTH);
   assign page_ok   = 32'(req_page_index) < 32'(MAX_PAGES);
   assign too_big   = 32'(req_end_position) > 32'(LIMIT);
   assign page_live = 32'(req_page_index) < 32'(alloc_ff[slot_idx]);
   assign load_addr = FA_W'(shard_idx) * FA_W'(FREE_DEPTH) + FA_W'(req_entry_index);
   assign read_addr = TA_W'(slot_idx) * TA_W'(MAX_PAGES) + TA_W'(req_page_index);

   // A grow-only request keeps the larger of the old and new page counts.
   assign next_w    = (rst_ff || need_ff > old_ff) ? need_ff : old_ff;
   assign limit_w   = (old_ff > next_ff) ? old_ff : next_ff;
   assign t_addr_w  = TA_W'(slot_ff) * TA_W'(MAX_PAGES) + TA_W'(pg_ff);
   assign push_addr = FA_W'(sh_ff) * FA_W'(FREE_DEPTH) + FA_W'(c_ff);
   assign pop_addr  = FA_W'(sh_ff) * FA_W'(FREE_DEPTH) + FA_W'(c_ff - FC_W'(1));
   // Pages below the old count are kept by a grow-only request.
   assign pop_go     = rst_ff || (pg_ff >= PG_W'(old_ff));
   assign last_shard = sh_ff == SH_W'(SP_COUNT - 1);
   assign sh_step    = last_shard ? '0 : sh_ff + SH_W'(1);

   // Per-shard feasibility: a reset request must fit the returned IDs and then
   // find enough IDs; a grow request must find the extra IDs.
   always_comb begin
      chk_err = 1'b0;
      for (int k = 0; k < SP_COUNT; k++) begin
         sum_w[k] = CW'(fcnt_ff[k]) + CW'(oc_ff[k]);
         if (rst_ff) begin
            if (sum_w[k] > CW'(FREE_DEPTH) || sum_w[k] < CW'(nc_ff[k])) begin
               chk_err = 1'b1;
            end
         end else if (nc_ff[k] > oc_ff[k] &&
                      CW'(fcnt_ff[k]) < CW'(nc_ff[k]) - CW'(oc_ff[k])) begin
            chk_err = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      alloc_in      = alloc_ff;
      fcnt_in       = fcnt_ff;
      slot_in       = slot_ff;
      rst_in        = rst_ff;
      end_in        = end_ff;
      old_in        = old_ff;
      need_in       = need_ff;
      next_in       = next_ff;
      acc_in        = acc_ff;
      pg_in         = pg_ff;
      sh_in         = sh_ff;
      oc_in         = oc_ff;
      nc_in         = nc_ff;
      c_in          = c_ff;
      res_status_in = res_status_ff;
      res_cnt_in    = res_cnt_ff;
      res_val_in    = res_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      t_we          = 1'b0;
      t_waddr       = t_addr_w;
      t_wdata       = '0;
      t_raddr       = t_addr_w;
      f_we          = 1'b0;
      f_waddr       = push_addr;
      f_wdata       = '0;
      f_raddr       = pop_addr;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_cnt_in    = '0;
               res_val_in    = '0;
               res_status_in = ST_UNCHANGED;
               state_in      = S_DONE;
               case (opcode_type'(req_opcode))
                  OP_REQUEST: begin
                     if (slot_ok) begin
                        slot_in    = slot_idx;
                        rst_in     = req_reset_request;
                        end_in     = req_end_position;
                        old_in     = alloc_ff[slot_idx];
                        res_cnt_in = alloc_ff[slot_idx];
                        acc_in     = '0;
                        need_in    = '0;
                        if (too_big) begin
                           res_status_in = ST_TOO_BIG;
                        end else begin
                           state_in = S_NEED;
                        end
                     end
                  end
                  OP_LOAD_ENTRY: begin
                     if (shard_ok && entry_ok) begin
                        f_we          = 1'b1;
                        f_waddr       = load_addr;
                        f_wdata       = req_entry_value;
                        res_status_in = ST_DONE;
                     end
                  end
                  OP_SET_COUNT: begin
                     if (shard_ok) begin
                        fcnt_in[shard_idx] = (32'(req_free_count) > 32'(FREE_DEPTH)) ?
                                             FC_W'(FREE_DEPTH) : FC_W'(req_free_count);
                        res_status_in = ST_DONE;
                     end
                  end
                  OP_READ_TABLE: begin
                     if (slot_ok) begin
                        res_cnt_in = alloc_ff[slot_idx];
                        if (page_ok) begin
                           res_status_in = ST_DONE;
                           // Pages at or above the count read as zero without a table access.
                           if (page_live) begin
                              t_raddr  = read_addr;
                              state_in = S_TRD;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_NEED: begin
            if (ACC_W'(end_ff) > acc_ff) begin
               acc_in  = acc_ff + ACC_W'(PAGE_TOKENS);
               need_in = need_ff + CNT_W'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            next_in = next_w;
            if (!rst_ff && next_w == old_ff) begin
               res_status_in = ST_UNCHANGED;
               state_in      = S_DONE;
            end else begin
               pg_in = '0;
               sh_in = '0;
               for (int k = 0; k < SP_COUNT; k++) begin
                  oc_in[k] = '0;
                  nc_in[k] = '0;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Count old and new pages per shard, one page a cycle.
            if (pg_ff < PG_W'(limit_w)) begin
               if (pg_ff < PG_W'(old_ff)) begin
                  oc_in[sh_ff] = oc_ff[sh_ff] + CNT_W'(1);
               end
               if (pg_ff < PG_W'(next_ff)) begin
                  nc_in[sh_ff] = nc_ff[sh_ff] + CNT_W'(1);
               end
               pg_in = pg_ff + PG_W'(1);
               sh_in = sh_step;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (chk_err) begin
               res_status_in = ST_NO_IDS;
               state_in      = S_DONE;
            end else begin
               sh_in    = '0;
               state_in = S_SH_START;
            end
         end
         S_SH_START: begin
            c_in     = fcnt_ff[sh_ff];
            pg_in    = PG_W'(sh_ff);
            state_in = rst_ff ? S_PUSH_RD : S_POP_CHK;
         end
         S_PUSH_RD: begin
            if (pg_ff < PG_W'(old_ff)) begin
               t_we     = 1'b1;
               state_in = S_PUSH_WR;
            end else begin
               pg_in    = PG_W'(sh_ff);
               state_in = S_POP_CHK;
            end
         end
         S_PUSH_WR: begin
            f_we     = 1'b1;
            f_wdata  = t_rdata;
            c_in     = c_ff + FC_W'(1);
            pg_in    = pg_ff + PG_W'(SP_COUNT);
            state_in = S_PUSH_RD;
         end
         S_POP_CHK: begin
            if (pg_ff < PG_W'(next_ff)) begin
               if (pop_go) begin
                  f_we     = 1'b1;
                  f_waddr  = pop_addr;
                  c_in     = c_ff - FC_W'(1);
                  state_in = S_POP_WR;
               end else begin
                  pg_in = pg_ff + PG_W'(SP_COUNT);
               end
            end else begin
               fcnt_in[sh_ff] = c_ff;
               if (last_shard) begin
                  alloc_in[slot_ff] = next_ff;
                  res_status_in     = ST_DONE;
                  res_cnt_in        = next_ff;
                  state_in          = S_DONE;
               end else begin
                  sh_in    = sh_step;
                  state_in = S_SH_START;
               end
            end
         end
         S_POP_WR: begin
            t_we     = 1'b1;
            t_wdata  = f_rdata;
            pg_in    = pg_ff + PG_W'(SP_COUNT);
            state_in = S_POP_CHK;
         end
         S_TRD: begin
            res_val_in = t_rdata;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = PCOUNT_W'(res_cnt_ff);
               rsp_value_in  = res_val_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SLOTS; k++) begin
            alloc_ff[k] <= '0;
         end
         for (int k = 0; k < SP_COUNT; k++) begin
            fcnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         fcnt_ff      <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      rst_ff        <= rst_in;
      end_ff        <= end_in;
      old_ff        <= old_in;
      need_ff       <= need_in;
      next_ff       <= next_in;
      acc_ff        <= acc_in;
      pg_ff         <= pg_in;
      sh_ff         <= sh_in;
      oc_ff         <= oc_in;
      nc_ff         <= nc_in;
      c_ff          <= c_in;
      res_status_ff <= res_status_in;
      res_cnt_ff    <= res_cnt_in;
      res_val_ff    <= res_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Page table: one entry per slot and logical page.
   paca_ram #(.WIDTH(ID_W), .DEPTH(SLOTS * MAX_PAGES)) u_table_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   // Free-ID stacks, one region of FREE_DEPTH entries per shard.
   paca_ram #(.WIDTH(ID_W), .DEPTH(SP_COUNT * FREE_DEPTH)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_count = rsp_count_ff;
   assign rsp_read_value = rsp_value_ff;

   always_comb begin
      fc_bound_ok    = 1'b1;
      alloc_bound_ok = 1'b1;
      for (int k = 0; k < SP_COUNT; k++) begin
         if (32'(fcnt_ff[k]) > 32'(FREE_DEPTH)) begin
            fc_bound_ok = 1'b0;
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (32'(alloc_ff[k]) > 32'(MAX_PAGES)) begin
            alloc_bound_ok = 1'b0;
         end
      end
   end

   `ASSERT_ALWAYS(a_free_count_bound, fc_bound_ok, "free count above stack depth")
   `ASSERT_ALWAYS(a_alloc_bound, alloc_bound_ok, "page count above table size")
   `ASSERT_IMPLIES(a_no_underflow, state_ff == S_POP_CHK && f_we, c_ff != '0, "stack underflow")
   `ASSERT_IMPLIES(a_no_overflow, state_ff == S_PUSH_WR, 32'(c_ff) < 32'(FREE_DEPTH), "stack overflow")
endmodule

// ===== bench/tb_paged_cache_page_allocator_core.sv =====
// Self-checking testbench for the paged cache page allocator core.
module tb_paged_cache_page_allocator_core;
   import paca_pkg::*;

   localparam int SHARDS = SP_COUNT_DEF;
   localparam int TOKENS = PAGE_TOKENS_DEF;
   localparam int NSLOTS = SLOTS_DEF;
   localparam int PAGES  = MAX_PAGES_DEF;
   localparam int DEPTH  = FREE_DEPTH_DEF;

   typedef struct packed {
      status_type          status;
      logic [PCOUNT_W-1:0] page_count;
      logic [ID_W-1:0]     read_value;
   } alloc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic                req_reset_request = 1'b0;
   logic [END_W-1:0]    req_end_position = '0;
   logic [SHARD_W-1:0]  req_shard_index = '0;
   logic [ENTRY_W-1:0]  req_entry_index = '0;
   logic [ID_W-1:0]     req_entry_value = '0;
   logic [FCOUNT_W-1:0] req_free_count = '0;
   logic [PAGE_W-1:0]   req_page_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PCOUNT_W-1:0] rsp_page_count;
   logic [ID_W-1:0]     rsp_read_value;

   paged_cache_page_allocator_core uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the allocator state. A written flag per stack entry lets
   // random stimulus steer clear of popping IDs that were never loaded.
   logic [ID_W-1:0]     table_mirror [NSLOTS][PAGES];
   logic [PCOUNT_W-1:0] pages_mirror [NSLOTS];
   logic [ID_W-1:0]     stack_mirror [SHARDS][DEPTH];
   bit                  stack_loaded [SHARDS][DEPTH];
   int                  count_mirror [SHARDS];

   alloc_result_type expected_results[$];
   int  mismatches = 0;
   int  burst_left = 0;
   bit  long_hold = 0;

   // Number of a slot's pages that fall into one shard.
   function automatic int shard_pages(int pages, int sh);
      return pages / SHARDS + ((sh < pages % SHARDS) ? 1 : 0);
   endfunction

   function automatic int pages_needed(int endp);
      return (endp + TOKENS - 1) / TOKENS;
   endfunction

   // Decides the outcome of a page request without touching the state.
   function automatic status_type request_outcome(int sl, bit rst, int endp);
      int old_n, next_n, oc, nc, c;
      old_n = int'(pages_mirror[sl]);
      next_n = (rst || pages_needed(endp) > old_n) ? pages_needed(endp) : old_n;
      if (!rst && next_n == old_n) return ST_UNCHANGED;
      if (next_n > PAGES) return ST_TOO_BIG;
      for (int sh = 0; sh < SHARDS; sh++) begin
         oc = shard_pages(old_n, sh);
         nc = shard_pages(next_n, sh);
         c = count_mirror[sh];
         if (rst) begin
            if (c + oc > DEPTH || c + oc < nc) return ST_NO_IDS;
         end else if (nc > oc && c < nc - oc) begin
            return ST_NO_IDS;
         end
      end
      return ST_DONE;
   endfunction

   // True when a successful request would pop only stack entries that hold a
   // loaded ID. Pushed IDs count as loaded.
   function automatic bit request_is_safe(int sl, bit rst, int endp);
      int old_n, next_n, oc, nc, c, lo, hi;
      if (request_outcome(sl, rst, endp) != ST_DONE) return 1;
      old_n = int'(pages_mirror[sl]);
      next_n = (rst || pages_needed(endp) > old_n) ? pages_needed(endp) : old_n;
      for (int sh = 0; sh < SHARDS; sh++) begin
         oc = shard_pages(old_n, sh);
         nc = shard_pages(next_n, sh);
         c = count_mirror[sh];
         lo = rst ? c + oc - nc : c - (nc - oc);
         hi = rst ? c - 1 : c - 1;
         for (int p = lo; p <= hi; p++)
            if (p >= 0 && !stack_loaded[sh][p]) return 0;
      end
      return 1;
   endfunction

   // Applies one accepted beat to the shadow state and returns its result.
   function automatic alloc_result_type predict_allocation(opcode_type op, int sl, bit rst,
         int endp, int sh, int ei, int ev, int fc, int pi);
      alloc_result_type r;
      int old_n, next_n, oc, nc, c, pg;
      r = '{status: ST_DONE, page_count: '0, read_value: '0};
      case (op)
         OP_REQUEST: begin
            r.status = request_outcome(sl, rst, endp);
            r.page_count = pages_mirror[sl];
            if (r.status == ST_DONE) begin
               old_n = int'(pages_mirror[sl]);
               next_n = (rst || pages_needed(endp) > old_n) ? pages_needed(endp) : old_n;
               for (int s = 0; s < SHARDS; s++) begin
                  oc = shard_pages(old_n, s);
                  nc = shard_pages(next_n, s);
                  c = count_mirror[s];
                  if (rst) begin
                     for (int i = 0; i < oc; i++) begin
                        pg = s + i * SHARDS;
                        stack_mirror[s][c] = table_mirror[sl][pg];
                        stack_loaded[s][c] = 1;
                        c++;
                        table_mirror[sl][pg] = '0;
                     end
                  end
                  for (int i = rst ? 0 : oc; i < nc; i++) begin
                     c--;
                     table_mirror[sl][s + i * SHARDS] = stack_mirror[s][c];
                     stack_mirror[s][c] = '0;
                  end
                  count_mirror[s] = c;
               end
               pages_mirror[sl] = PCOUNT_W'(next_n);
               r.page_count = PCOUNT_W'(next_n);
            end
         end
         OP_LOAD_ENTRY: begin
            stack_mirror[sh][ei] = ID_W'(ev);
            stack_loaded[sh][ei] = 1;
         end
         OP_SET_COUNT: count_mirror[sh] = (fc > DEPTH) ? DEPTH : fc;
         default: begin
            r.page_count = pages_mirror[sl];
            r.read_value = table_mirror[sl][pi];
         end
      endcase
      return r;
   endfunction

   // Offers one beat, waits for it to be taken, records the expected result,
   // then sometimes ends the burst with an idle gap.
   task automatic send_item(opcode_type op, int sl, bit rst, int endp, int sh,
         int ei, int ev, int fc, int pi);
      req_opcode        <= op;
      req_slot          <= SLOT_W'(sl);
      req_reset_request <= rst;
      req_end_position  <= END_W'(endp);
      req_shard_index   <= SHARD_W'(sh);
      req_entry_index   <= ENTRY_W'(ei);
      req_entry_value   <= ID_W'(ev);
      req_free_count    <= FCOUNT_W'(fc);
      req_page_index    <= PAGE_W'(pi);
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_allocation(op, sl, rst, endp, sh, ei, ev, fc, pi));
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_request(int sl, bit rst, int endp);
      send_item(OP_REQUEST, sl, rst, endp, $urandom_range(0, 3), $urandom_range(0, 255),
                $urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 63));
   endtask

   task automatic send_load(int sh, int ei, int ev);
      send_item(OP_LOAD_ENTRY, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                $urandom_range(0, 65535), sh, ei, ev, $urandom_range(0, 511),
                $urandom_range(0, 63));
   endtask

   task automatic send_count(int sh, int fc);
      send_item(OP_SET_COUNT, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                $urandom_range(0, 65535), sh, $urandom_range(0, 255),
                $urandom_range(0, 65535), fc, $urandom_range(0, 63));
   endtask

   task automatic send_read(int sl, int pi);
      send_item(OP_READ_TABLE, sl, 1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                $urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 65535),
                $urandom_range(0, 511), pi);
   endtask

   // Right after reset: empty table, empty stacks, no-op and oversize requests.
   task automatic test_reset_state();
      send_read(0, 0);
      send_read(31, 63);
      send_request(0, 1'b0, 0);
      send_request(1, 1'b1, 0);
      send_request(2, 1'b0, 65535);
      send_request(3, 1'b0, 1);
   endtask

   // One ID per shard, then a four page request, a read back, an unchanged request and a grow that finds no ID.
   task automatic test_first_allocation();
      for (int sh = 0; sh < SHARDS; sh++) send_load(sh, 0, 16'h1000 + sh);
      send_load(3, 255, 16'hFFFF);
      send_count(0, 0);
      for (int sh = 0; sh < SHARDS; sh++) send_count(sh, 1);
      send_request(5, 1'b0, 128);
      send_read(5, 3);
      send_request(5, 1'b0, 100);
      send_request(5, 1'b0, 129);
   endtask

   // Pushing the old IDs back onto a full stack must reject the request,
   // and a count above the stack depth saturates.
   task automatic test_stack_limits();
      send_count(0, 511);
      send_request(5, 1'b1, 32);
      send_count(0, 0);
      send_request(5, 1'b1, 32);
      send_read(5, 0);
   endtask

   // Mostly well-formed traffic: loads keep the stacks stocked so that
   // requests grow, shrink and reset slots deep into the table.
   task automatic test_random_traffic(int beats);
      int pick, sl, endp;
      bit rst;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_load($urandom_range(0, 3),
                      ($urandom_range(0, 2) != 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 255),
                      $urandom_range(0, 65535));
         end else if (pick < 45) begin
            send_count($urandom_range(0, 3),
                       ($urandom_range(0, 29) != 0) ? $urandom_range(0, 48)
                                                    : $urandom_range(0, 511));
         end else if (pick < 85) begin
            sl = $urandom_range(0, 31);
            rst = ($urandom_range(0, 9) < 3);
            case ($urandom_range(0, 19))
               0:       endp = $urandom_range(0, 65535);
               1:       endp = $urandom_range(2049, 65535);
               2, 3, 4: endp = $urandom_range(0, 2048);
               default: endp = $urandom_range(0, 700);
            endcase
            if (request_is_safe(sl, rst, endp)) send_request(sl, rst, endp);
            else send_read(sl, $urandom_range(0, 63));
         end else begin
            send_read($urandom_range(0, 31), $urandom_range(0, 63));
         end
      end
   endtask

   // The receiver holds off for a long stretch while beats keep coming.
   task automatic test_backpressure();
      long_hold = 1;
      burst_left = 40;
      test_random_traffic(40);
   endtask

   // Receiver stall pattern: runs of no stall, random stall and periodic
   // stall, plus one long hold-off on request.
   initial begin
      int mode;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 2);
         for (int k = $urandom_range(10, 60); k > 0; k--) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= (k % 4 == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Compares each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: status %0d count %0d value %h",
                        rsp_status, rsp_page_count, rsp_read_value);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_page_count !== want.page_count ||
                rsp_read_value !== want.read_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected status %0d count %0d value %h, got %0d %0d %h",
                           want.status, want.page_count, want.read_value,
                           rsp_status, rsp_page_count, rsp_read_value);
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < NSLOTS; s++) begin
         pages_mirror[s] = '0;
         for (int p = 0; p < PAGES; p++) table_mirror[s][p] = '0;
      end
      for (int sh = 0; sh < SHARDS; sh++) begin
         count_mirror[sh] = 0;
         for (int e = 0; e < DEPTH; e++) begin
            stack_mirror[sh][e] = '0;
            stack_loaded[sh][e] = 0;
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_first_allocation();
      test_stack_limits();
      test_random_traffic(600);
      test_backpressure();
      test_random_traffic(530);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
